// File: hdl/dap_pkg.sv
// Shared types, codes and the digit-accumulate helper of the decimal amount parser.
package dap_pkg;

	localparam int unsigned MAX_SCALE = 18;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
	localparam logic [2:0] ST_INVALID     = 3'd2;
	localparam logic [2:0] ST_OVERFLOW    = 3'd3;
	localparam logic [2:0] ST_NEGZERO     = 3'd4;

	localparam logic CFG_CURRENCY = 1'b0;
	localparam logic CFG_SCALE    = 1'b1;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [63:0] amount;
	} out_item_t;

	// one closed string handed from the front to the back
	typedef struct packed {
		logic [2:0]  pre_status;
		logic        neg;
		logic [63:0] mag;
		logic        ovf;
		logic [4:0]  pad;
	} str_job_t;

	typedef struct packed {
		logic        ovf;
		logic [63:0] mag;
	} push_res_t;

	// mag * 10 + d, checked against 2^63-1 (2^63 when negative)
	function automatic push_res_t dap_push(input logic [63:0] mag, input logic [3:0] d,
	                                       input logic neg);
		logic [67:0] prod;
		logic [67:0] limit;
		push_res_t   r;
		prod  = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {64'b0, d};
		limit = {5'b0, {63{1'b1}}} + {67'b0, neg};
		r.ovf = (prod > limit);
		r.mag = r.ovf ? mag : prod[63:0];
		return r;
	endfunction

endpackage

// File: hdl/dap_front.sv
// Front part: takes characters, tracks the grammar and accumulates the magnitude.
module dap_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dap_pkg::in_item_t in_data,
	input  logic              cur_ok,
	input  logic [4:0]        scale_raw,
	input  logic              q_full,
	output logic              q_push,
	output dap_pkg::str_job_t q_data
);
	import dap_pkg::*;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_INT   = 3'd2;
	localparam logic [2:0] PH_POINT = 3'd3;
	localparam logic [2:0] PH_FRAC  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [63:0] mag_q, mag_d;
	logic [1:0]  icnt_q, icnt_d;
	logic        fzero_q, fzero_d;
	logic [4:0]  fcnt_q, fcnt_d;
	logic        fbad_q, fbad_d;
	logic        ovf_q, ovf_d;

	logic        accept, take_char, is_digit, bad;
	logic [3:0]  dval;
	logic [4:0]  scale;
	push_res_t   pr;

	// an end item needs a free queue slot, characters never wait
	assign in_ready  = !(in_data.end_req && q_full);
	assign accept    = in_valid && in_ready;
	assign take_char = accept && !in_data.end_req;
	assign q_push    = accept && in_data.end_req;

	assign is_digit = (in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE);
	assign dval     = 4'(in_data.ch - CH_ZERO);
	assign pr       = dap_push(mag_q, dval, neg_q);

	assign scale = (scale_raw > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : scale_raw;
	assign bad   = fbad_q || phase_q == PH_START || phase_q == PH_SIGN ||
	               phase_q == PH_POINT ||
	               (phase_q == PH_FRAC && (scale == 5'd0 || fcnt_q > scale));

	always_comb begin
		q_data.pre_status = !cur_ok ? ST_UNSUPPORTED : (bad ? ST_INVALID : ST_OK);
		q_data.neg        = neg_q;
		q_data.mag        = mag_q;
		q_data.ovf        = ovf_q;
		q_data.pad        = scale - fcnt_q;
	end

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		icnt_d  = icnt_q;
		fzero_d = fzero_q;
		fcnt_d  = fcnt_q;
		fbad_d  = fbad_q;
		ovf_d   = ovf_q;
		if (q_push) begin
			phase_d = PH_START;
			neg_d   = 1'b0;
			mag_d   = '0;
			icnt_d  = '0;
			fzero_d = 1'b0;
			fcnt_d  = '0;
			fbad_d  = 1'b0;
			ovf_d   = 1'b0;
		end else if (take_char && !fbad_q) begin
			unique case (phase_q)
				PH_START, PH_SIGN, PH_INT: begin
					if (phase_q == PH_START && in_data.ch == CH_MINUS) begin
						neg_d   = 1'b1;
						phase_d = PH_SIGN;
					end else if (is_digit) begin
						if (icnt_q == 2'd0) begin
							fzero_d = (dval == 4'd0);
						end else if (fzero_q) begin
							fbad_d = 1'b1;
						end
						if (icnt_q < 2'd2) begin
							icnt_d = icnt_q + 2'd1;
						end
						if (!ovf_q) begin
							ovf_d = pr.ovf;
							mag_d = pr.mag;
						end
						phase_d = PH_INT;
					end else if (phase_q == PH_INT && in_data.ch == CH_POINT) begin
						phase_d = PH_POINT;
					end else begin
						fbad_d = 1'b1;
					end
				end
				PH_POINT, PH_FRAC: begin
					if (is_digit) begin
						if (fcnt_q != 5'd31) begin
							fcnt_d = fcnt_q + 5'd1;
						end
						if (!ovf_q) begin
							ovf_d = pr.ovf;
							mag_d = pr.mag;
						end
						phase_d = PH_FRAC;
					end else begin
						fbad_d = 1'b1;
					end
				end
				default: fbad_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			icnt_q  <= '0;
			fzero_q <= 1'b0;
			fcnt_q  <= '0;
			fbad_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			icnt_q  <= icnt_d;
			fzero_q <= fzero_d;
			fcnt_q  <= fcnt_d;
			fbad_q  <= fbad_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

// File: hdl/dap_queue.sv
// Small register queue carrying closed strings from the front to the back.
module dap_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dap_pkg::str_job_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output dap_pkg::str_job_t pop_data
);
	import dap_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	str_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/dap_back.sv
// Back part: pads missing fraction digits one per cycle and forms the result.
module dap_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  dap_pkg::str_job_t  q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output dap_pkg::out_item_t out_data
);
	import dap_pkg::*;

	logic        busy_q;
	logic [2:0]  pre_q;
	logic        neg_q;
	logic [63:0] mag_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        stepping, finish;
	push_res_t   pr;
	out_item_t   res;

	assign q_pop    = q_valid && !busy_q;
	assign stepping = busy_q && pre_q == ST_OK && cnt_q != 5'd0;
	assign finish   = busy_q && !stepping && (!out_valid_q || out_ready);
	assign pr       = dap_push(mag_q, 4'd0, neg_q);

	always_comb begin
		res.status = ST_OK;
		res.amount = '0;
		priority if (pre_q != ST_OK) begin
			res.status = pre_q;
		end else if (ovf_q) begin
			res.status = ST_OVERFLOW;
		end else if (neg_q && mag_q == '0) begin
			res.status = ST_NEGZERO;
		end else begin
			res.amount = neg_q ? -$signed(mag_q) : $signed(mag_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pre_q <= q_data.pre_status;
			neg_q <= q_data.neg;
			mag_q <= q_data.mag;
			ovf_q <= q_data.ovf;
			cnt_q <= q_data.pad;
		end else if (stepping) begin
			cnt_q <= cnt_q - 5'd1;
			if (!ovf_q) begin
				ovf_q <= pr.ovf;
				mag_q <= pr.mag;
			end
		end
		if (finish) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/decimal_amount_parser.sv
// Top level of the streaming ASCII decimal amount parser.
// Usage: characters of an amount enter on the in channel (valid/ready), one item
// per character; an item with end_req set closes the string and yields one result
// item (status, amount in minor units) on the out channel. Character items yield
// nothing. The config port (cfg_we, cfg_index, cfg_data) sets currency_supported
// (index 0) and scale_digits (index 1); write it only while no string is open.
// Throughput: one character per cycle, sustained. An end item waits in a small
// queue and is then worked by the back end, which appends one zero digit per
// cycle for each fraction digit missing against the scale.
// Each end item goes through the queue, the back end (zero padding, only when the
// string is accepted) and the output register in that order. The back end works
// one string at a time, so short strings back up into the queue; when it is full,
// end items are held off, characters still flow.
// A stalled receiver holds the result register; the back end and queue then fill
// and end items wait. Reset clears the parse state, the queue and the output, and
// restores currency_supported = 1 and scale_digits = 2.
module decimal_amount_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dap_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dap_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data
);
	import dap_pkg::*;

	logic       cur_ok_q;
	logic [4:0] scale_q;
	logic       q_push, q_full, q_pop, q_valid;
	str_job_t   q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ok_q <= 1'b1;
			scale_q  <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CURRENCY: cur_ok_q <= cfg_data[0];
				CFG_SCALE:    scale_q  <= cfg_data;
				default:      scale_q  <= scale_q;
			endcase
		end
	end

	dap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cur_ok    (cur_ok_q),
		.scale_raw (scale_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	dap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	dap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full || q_pop)
		else $error("queue written while full");

	a_amount_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.amount == '0)
		else $error("nonzero amount with error status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_NEGZERO)
		else $error("status code out of range");

	a_end_held_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_data.end_req && q_full |-> !in_ready)
		else $error("end item taken with queue full");

endmodule

// File: tb/decimal_amount_parser_tb.sv
// Self-checking testbench of the decimal amount parser: directed and random strings, scoreboard.
module decimal_amount_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dap_pkg::*;

	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 64;
	localparam int NUM_PHASES   = 8;

	typedef enum logic [2:0] {AT_START, AT_SIGN, AT_INT, AT_POINT, AT_FRAC} text_pos_e;

	class amount_scoreboard;
		bit          currency_ok = 1'b1;
		logic [4:0]  scale_reg   = 5'd2;
		text_pos_e   pos;
		bit          negative;
		logic [63:0] mag;
		logic [1:0]  int_digits;
		bit          lead_zero;
		logic [4:0]  frac_digits;
		bit          syntax_bad;
		bit          overflowed;
		out_item_t   amounts_due[$];
		int          failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			pos         = AT_START;
			negative    = 1'b0;
			mag         = '0;
			int_digits  = '0;
			lead_zero   = 1'b0;
			frac_digits = '0;
			syntax_bad  = 1'b0;
			overflowed  = 1'b0;
		endfunction

		function void write_reg(logic idx, logic [4:0] val);
			if (idx == CFG_CURRENCY) currency_ok = val[0];
			else scale_reg = val;
		endfunction

		function int pending();
			return amounts_due.size();
		endfunction

		// freeze the magnitude once it would pass the signed limit
		function void push_digit(logic [3:0] d);
			logic [63:0] lim;
			if (overflowed) return;
			lim = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, negative};
			if (mag > (lim - {60'd0, d}) / 64'd10) overflowed = 1'b1;
			else mag = mag * 64'd10 + {60'd0, d};
		endfunction

		function void take_char(logic [7:0] c);
			bit         is_digit;
			logic [3:0] d;
			is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
			d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
			if (syntax_bad) return;
			case (pos)
				AT_START, AT_SIGN, AT_INT: begin
					if (pos == AT_START && c == CH_MINUS) begin
						negative = 1'b1;
						pos = AT_SIGN;
					end else if (is_digit) begin
						if (int_digits == 2'd0) lead_zero = (d == 4'd0);
						else if (lead_zero) syntax_bad = 1'b1;
						if (int_digits < 2'd2) int_digits++;
						push_digit(d);
						pos = AT_INT;
					end else if (pos == AT_INT && c == CH_POINT) begin
						pos = AT_POINT;
					end else begin
						syntax_bad = 1'b1;
					end
				end
				AT_POINT, AT_FRAC: begin
					if (is_digit) begin
						if (frac_digits < 5'd31) frac_digits++;
						push_digit(d);
						pos = AT_FRAC;
					end else begin
						syntax_bad = 1'b1;
					end
				end
				default: syntax_bad = 1'b1;
			endcase
		endfunction

		function out_item_t close_string();
			out_item_t r;
			int        sc;
			int        i;
			bit        bad;
			sc = (scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg);
			bad = syntax_bad || pos == AT_START || pos == AT_SIGN || pos == AT_POINT ||
				(pos == AT_FRAC && (sc == 0 || int'(frac_digits) > sc));
			r.status = ST_OK;
			r.amount = '0;
			if (!currency_ok) begin
				r.status = ST_UNSUPPORTED;
			end else if (bad) begin
				r.status = ST_INVALID;
			end else begin
				// pad the missing minor-unit digits with zeros
				for (i = int'(frac_digits); i < sc; i++) push_digit(4'd0);
				if (overflowed) r.status = ST_OVERFLOW;
				else if (negative && mag == 64'd0) r.status = ST_NEGZERO;
				else r.amount = negative ? -mag : mag;
			end
			restart();
			return r;
		endfunction

		function void note_input(in_item_t it);
			if (it.end_req) amounts_due.push_back(close_string());
			else take_char(it.ch);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (amounts_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: status %0d amount %0d", got.status, got.amount);
				return;
			end
			want = amounts_due.pop_front();
			if (got.status !== want.status || got.amount !== want.amount) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: want status %0d amount %0d, got status %0d amount %0d",
						want.status, want.amount, got.status, got.amount);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic [4:0] cfg_data  = '0;

	amount_scoreboard sb = new();
	logic [7:0]       text[$];
	int               phase_items;
	bit               squeeze_req;
	bit               squeeze_done;

	decimal_amount_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic void gen_well_formed(input int sc);
		int n;
		int nf;
		bit zeros;
		if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
		if ($urandom_range(0, 3) == 0) begin
			text.push_back(CH_ZERO);
		end else begin
			text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 21) : $urandom_range(0, 4);
			repeat (n) text.push_back(rand_digit());
		end
		// now and then a point with no room for it, or one digit too many
		if ((sc > 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 19) == 0) begin
			text.push_back(CH_POINT);
			nf = ($urandom_range(0, 9) == 0) ? sc + 1 : $urandom_range(1, (sc > 0) ? sc : 1);
			zeros = ($urandom_range(0, 4) == 0);
			repeat (nf) text.push_back(zeros ? CH_ZERO : rand_digit());
		end
	endfunction

	// amounts a few minor units either side of the signed 64-bit limit
	function automatic void gen_limit(input int sc);
		bit          neg;
		logic [63:0] target;
		logic [63:0] unit;
		logic [63:0] ip;
		logic [63:0] fp;
		string       s;
		int          keep;
		neg = $urandom_range(0, 1);
		target = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, neg};
		if ($urandom_range(0, 1)) target = target + 64'd1 + 64'($urandom_range(0, 3));
		else target = target - 64'($urandom_range(0, 3));
		unit = 64'd1;
		repeat (sc) unit = unit * 64'd10;
		ip = target / unit;
		fp = target % unit;
		if (neg) text.push_back(CH_MINUS);
		s = $sformatf("%0d", ip);
		foreach (s[i]) text.push_back(s[i]);
		if (sc > 0) begin
			text.push_back(CH_POINT);
			keep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sc) : sc;
			repeat (keep) begin
				unit = unit / 64'd10;
				text.push_back(CH_ZERO + 8'(fp / unit % 64'd10));
			end
		end
	endfunction

	function automatic void gen_broken(input int sc);
		int pos;
		case ($urandom_range(0, 5))
			0: ;
			1: text.push_back(CH_MINUS);
			2: begin
				text.push_back(rand_digit());
				text.push_back(CH_POINT);
			end
			3: begin
				text.push_back(CH_ZERO);
				repeat ($urandom_range(1, 3)) text.push_back(rand_digit());
			end
			4: begin
				gen_well_formed(sc);
				pos = $urandom_range(0, text.size());
				text.insert(pos, 8'($urandom_range(0, 255)));
			end
			default: repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		endcase
	endfunction

	task automatic send_item(input logic [7:0] c, input logic is_end, input bit quiet);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		in_data.ch      <= c;
		in_data.end_req <= is_end;
		do @(posedge clk); while (!in_ready);
		sb.note_input(in_data);
		phase_items++;
	endtask

	// send the buffered text followed by its end item
	task automatic send_text(input bit quiet);
		foreach (text[i]) send_item(text[i], 1'b0, quiet);
		send_item(8'($urandom_range(0, 255)), 1'b1, quiet);
		text.delete();
	endtask

	task automatic send_str(input string s);
		foreach (s[i]) text.push_back(s[i]);
		send_text(1'b0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	initial begin : result_sink
		int stall;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// starve the output once so that the block backs up into its input
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0) quiet = !quiet;
			stall = quiet ? 0 : pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		logic       cur_set[NUM_PHASES];
		logic [4:0] scale_set[NUM_PHASES];
		int         sc;
		int         pick;
		cur_set   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
		scale_set = '{5'd0, 5'd18, 5'd31, 5'd2, 5'd19, 5'd1, 5'($urandom_range(0, 31)), 5'd17};
		squeeze_req  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: currency known, two minor-unit digits
		send_str("");
		send_str("-");
		send_str("-0");
		send_str("7.");
		send_str("01");
		send_str("-15");
		send_str("9.999");
		send_str("4a");
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(CFG_CURRENCY, {4'($urandom_range(0, 15)), cur_set[p]});
			write_reg(CFG_SCALE, scale_set[p]);
			sc = (scale_set[p] > MAX_SCALE) ? MAX_SCALE : int'(scale_set[p]);
			if (p == 2) squeeze_req = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) gen_well_formed(sc);
				else if (pick < 8) gen_limit(sc);
				else gen_broken(sc);
				send_text(p % 2 == 0);
			end
			wait_idle();
		end

		if (sb.failures + sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
